// ===== rtl/imtseq_pkg.sv =====
// package: types and codes shared by the i2c master transaction sequencer
`timescale 1ns / 1ps

package imtseq_pkg;

    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_DONE    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_REG    = 3'd2,
        PH_RSTART = 3'd3,
        PH_WDATA  = 3'd4,
        PH_RDATA  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_RSTART = 3'd3,
        ACT_RX_ACK = 3'd4,
        ACT_RX_NAK = 3'd5,
        ACT_STOP   = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_SUCCESS  = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_BAD_REG  = 3'd4,
        ST_XFER     = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        is_read;
        logic        use_register;
        logic [6:0]  slave_address;
        logic [7:0]  register_address;
        logic [15:0] byte_count;
        logic [7:0]  write_data;
        logic        ack_received;
        logic        transfer_complete;
        logic [7:0]  received_byte;
    } in_item_t;

    typedef struct packed {
        action_t     bus_action;
        logic [7:0]  send_byte;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        finished;
        status_t     status;
    } res_item_t;

endpackage

// ===== rtl/i2c_master_transaction_sequencer_core.sv =====
// top level: input register, step logic and result register
// an input beat waits in the input register; its result is then held in the result register
// throughput: one beat per cycle unless out_ready stalls; one result beat per input beat
// the input register frees whenever its beat moves into a free or draining result register
// reset: asynchronous, clears both registers' valid flags and the transaction state to idle
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_core #(
    parameter int COUNT_BITS = imtseq_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        is_read,
    input  logic        use_register,
    input  logic [6:0]  slave_address,
    input  logic [7:0]  register_address,
    input  logic [15:0] byte_count,
    input  logic [7:0]  write_data,
    input  logic        ack_received,
    input  logic        transfer_complete,
    input  logic [7:0]  received_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  bus_action,
    output logic [7:0]  send_byte,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        finished,
    output logic [2:0]  status
);
    import imtseq_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= '{opcode, is_read, use_register, slave_address, register_address,
                             byte_count, write_data, ack_received, transfer_complete,
                             received_byte};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    imtseq_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (in_item_reg),
        .res    (res_next)
    );

    assign out_valid  = out_valid_reg;
    assign bus_action = res_reg.bus_action;
    assign send_byte  = res_reg.send_byte;
    assign read_valid = res_reg.read_valid;
    assign read_data  = res_reg.read_data;
    assign finished   = res_reg.finished;
    assign status     = res_reg.status;

endmodule

// ===== rtl/imtseq_step.sv =====
// transaction state registers and the per-beat step logic
`timescale 1ns / 1ps

module imtseq_step #(
    parameter int COUNT_BITS = imtseq_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  imtseq_pkg::in_item_t  item,
    output imtseq_pkg::res_item_t res
);
    import imtseq_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  reading_reg, reading_next;
    logic                  regw_reg, regw_next;
    logic [6:0]            target_reg, target_next;
    logic [7:0]            regbyte_reg, regbyte_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;

    logic                  go_data;
    logic [COUNT_BITS-1:0] data_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            reading_reg <= 1'b0;
            regw_reg    <= 1'b0;
            target_reg  <= '0;
            regbyte_reg <= '0;
            left_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            reading_reg <= reading_next;
            regw_reg    <= regw_next;
            target_reg  <= target_next;
            regbyte_reg <= regbyte_next;
            left_reg    <= left_next;
        end
    end

    always_comb
    begin
        res          = '0;
        res.bus_action = ACT_NONE;
        res.status   = ST_BUSY;
        phase_next   = phase_reg;
        reading_next = reading_reg;
        regw_next    = regw_reg;
        target_next  = target_reg;
        regbyte_next = regbyte_reg;
        left_next    = left_reg;
        go_data      = 1'b0;
        data_cnt     = left_reg;

        case (opcode_t'(item.opcode))
            OP_BEGIN:
            begin
                reading_next   = item.is_read;
                regw_next      = item.use_register;
                target_next    = item.slave_address;
                regbyte_next   = item.register_address;
                left_next      = item.byte_count[COUNT_BITS-1:0];
                res.bus_action = ACT_START;
                res.send_byte  = {item.slave_address, item.is_read & ~item.use_register};
                phase_next     = PH_ADDR;
            end
            OP_TIMEOUT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res.finished = 1'b1;
                    res.status   = ST_TIMEOUT;
                    phase_next   = PH_IDLE;
                end
            end
            OP_DONE:
            begin
                case (phase_reg)
                    PH_ADDR:
                    begin
                        if (!item.ack_received)
                        begin
                            res.finished = 1'b1;
                            res.status   = ST_BAD_ADDR;
                            phase_next   = PH_IDLE;
                        end
                        else if (regw_reg)
                        begin
                            res.bus_action = ACT_SEND;
                            res.send_byte  = regbyte_reg;
                            phase_next     = PH_REG;
                        end
                        else
                        begin
                            go_data = 1'b1;
                        end
                    end
                    PH_REG:
                    begin
                        if (!item.ack_received)
                        begin
                            res.finished = 1'b1;
                            res.status   = ST_BAD_REG;
                            phase_next   = PH_IDLE;
                        end
                        else if (reading_reg)
                        begin
                            res.bus_action = ACT_RSTART;
                            res.send_byte  = {target_reg, 1'b1};
                            phase_next     = PH_RSTART;
                        end
                        else
                        begin
                            go_data = 1'b1;
                        end
                    end
                    PH_RSTART:
                    begin
                        if (!item.ack_received)
                        begin
                            res.finished = 1'b1;
                            res.status   = ST_BAD_ADDR;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            go_data = 1'b1;
                        end
                    end
                    PH_WDATA:
                    begin
                        if (!item.ack_received || !item.transfer_complete)
                        begin
                            res.finished = 1'b1;
                            res.status   = ST_XFER;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            data_cnt  = left_reg - COUNT_BITS'(1);
                            left_next = data_cnt;
                            go_data   = 1'b1;
                        end
                    end
                    PH_RDATA:
                    begin
                        res.read_valid = 1'b1;
                        res.read_data  = item.received_byte;
                        data_cnt       = left_reg - COUNT_BITS'(1);
                        left_next      = data_cnt;
                        go_data        = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // enter or continue the data part
        if (go_data)
        begin
            if (data_cnt == '0)
            begin
                res.bus_action = ACT_STOP;
                res.finished   = 1'b1;
                res.status     = ST_SUCCESS;
                phase_next     = PH_IDLE;
            end
            else if (reading_reg)
            begin
                res.bus_action = (data_cnt > COUNT_BITS'(1)) ? ACT_RX_ACK : ACT_RX_NAK;
                phase_next     = PH_RDATA;
            end
            else
            begin
                res.bus_action = ACT_SEND;
                res.send_byte  = item.write_data;
                phase_next     = PH_WDATA;
            end
        end
    end

endmodule
